// File: hdl/ipsc_pkg.sv
// Package for the inactivity power state controller.
// Holds the request and result types, command codes, level codes and register indexes.
// Depends on nothing; every file of the block imports it.
package ipsc_pkg;

    // Commands carried by one request.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_KICK  = 2'd2,
        CMD_FORCE = 2'd3
    } cmd_t;

    // Power levels, from highest power to lowest.
    localparam logic [2:0] LVL_ACTIVE      = 3'd0;
    localparam logic [2:0] LVL_DIM         = 3'd1;
    localparam logic [2:0] LVL_SCREEN_OFF  = 3'd2;
    localparam logic [2:0] LVL_LIGHT_SLEEP = 3'd3;
    localparam logic [2:0] LVL_DEEP_SLEEP  = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_AFTER        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_OFF_AFTER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_SLEEP_AFTER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BL_ACTIVE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BL_DIM           = 3'd4;

    localparam int unsigned CFG_DATA_W = 32;

    // Register values after reset.
    localparam logic [31:0] DIM_AFTER_RESET         = 32'd30000;
    localparam logic [31:0] SCREEN_OFF_AFTER_RESET  = 32'd60000;
    localparam logic [31:0] LIGHT_SLEEP_AFTER_RESET = 32'd300000;
    localparam logic [7:0]  BL_ACTIVE_RESET         = 8'd255;
    localparam logic [7:0]  BL_DIM_RESET            = 8'd64;

    // One request.
    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] target_level;
    } req_t;

    // One result.
    typedef struct packed {
        logic [2:0]  level_now;
        logic [7:0]  backlight;
        logic        backlight_write;
        logic        sleep_request;
        logic [31:0] ms_since_kick;
    } rsp_t;

endpackage

// File: hdl/inactivity_power_state_controller.sv
// Result: a request's result is registered, in the result register or the skid entry, before it is shown.
// Throughput: one request per cycle unless stalled; level and idle count update at acceptance.
// A skid entry behind the result register takes one request during an output stall;
// the request side then stalls until that entry has moved into the result register.
// Reset: level goes to active, the idle count to zero, the registers to their defaults,
// and the result buffer empties. Configuration writes are always ready.
module inactivity_power_state_controller #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     req_valid,
    output logic                                     req_stall,
    input  ipsc_pkg::req_t                           req,
    output logic                                     rsp_valid,
    input  logic                                     rsp_stall,
    output ipsc_pkg::rsp_t                           rsp,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ipsc_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import ipsc_pkg::*;

    // Compare width covers both the idle count and the 32-bit thresholds.
    localparam int unsigned CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [31:0]            dim_after_reg;
    logic [31:0]            screen_off_after_reg;
    logic [31:0]            light_sleep_after_reg;
    logic [7:0]             bl_active_reg;
    logic [7:0]             bl_dim_reg;

    logic [2:0]             power_level_reg;
    logic [2:0]             power_level_next;
    logic [COUNT_WIDTH-1:0] idle_ms_reg;
    logic [COUNT_WIDTH-1:0] idle_ms_next;

    logic                   out_valid_reg;
    rsp_t                   out_reg;
    logic                   skid_valid_reg;
    rsp_t                   skid_reg;

    logic                   accept;
    logic                   out_free;
    logic                   level_changed;
    logic [2:0]             want_level;
    logic [CMP_W-1:0]       idle_wide;
    logic [7:0]             backlight_next;
    rsp_t                   result;

    assign cfg_ready = 1'b1;

    // Configuration registers, written only while the block is idle; the user, not the block, enforces this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_after_reg         <= DIM_AFTER_RESET;
            screen_off_after_reg  <= SCREEN_OFF_AFTER_RESET;
            light_sleep_after_reg <= LIGHT_SLEEP_AFTER_RESET;
            bl_active_reg         <= BL_ACTIVE_RESET;
            bl_dim_reg            <= BL_DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIM_AFTER:         dim_after_reg         <= cfg_data[31:0];
                CFG_SCREEN_OFF_AFTER:  screen_off_after_reg  <= cfg_data[31:0];
                CFG_LIGHT_SLEEP_AFTER: light_sleep_after_reg <= cfg_data[31:0];
                CFG_BL_ACTIVE:         bl_active_reg         <= cfg_data[7:0];
                CFG_BL_DIM:            bl_dim_reg            <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: the skid entry must be empty to take a new request.
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Wanted level from the thresholds, in priority order.
    assign idle_wide = CMP_W'(idle_ms_reg);

    always_comb
    begin
        if (idle_wide >= CMP_W'(light_sleep_after_reg))
            want_level = LVL_LIGHT_SLEEP;
        else if (idle_wide >= CMP_W'(screen_off_after_reg))
            want_level = LVL_SCREEN_OFF;
        else if (idle_wide >= CMP_W'(dim_after_reg))
            want_level = LVL_DIM;
        else
            want_level = LVL_ACTIVE;
    end

    // Command decode and next state.
    always_comb
    begin
        power_level_next = power_level_reg;
        idle_ms_next     = idle_ms_reg;
        unique case (req.cmd)
            CMD_TICK:
            begin
                if (idle_ms_reg != {COUNT_WIDTH{1'b1}})
                    idle_ms_next = idle_ms_reg + COUNT_WIDTH'(1);
            end
            CMD_CHECK:
            begin
                if (want_level > power_level_reg)
                    power_level_next = want_level;
            end
            CMD_KICK:
            begin
                idle_ms_next     = '0;
                power_level_next = LVL_ACTIVE;
            end
            CMD_FORCE:
            begin
                if (req.target_level <= LVL_DEEP_SLEEP)
                    power_level_next = req.target_level;
            end
            default:
            begin
            end
        endcase
    end

    assign level_changed = (power_level_next != power_level_reg);

    // Backlight belonging to the new level.
    always_comb
    begin
        case (power_level_next)
            LVL_ACTIVE: backlight_next = bl_active_reg;
            LVL_DIM:    backlight_next = bl_dim_reg;
            default:    backlight_next = 8'd0;
        endcase
    end

    // Result fields; a wide count is capped at the 32-bit maximum.
    always_comb
    begin
        result.level_now       = power_level_next;
        result.backlight       = backlight_next;
        result.backlight_write = level_changed;
        result.sleep_request   = (power_level_next == LVL_DEEP_SLEEP);
        if (CMP_W'(idle_ms_next) > CMP_W'(32'hFFFF_FFFF))
            result.ms_since_kick = 32'hFFFF_FFFF;
        else
            result.ms_since_kick = 32'(CMP_W'(idle_ms_next));
    end

    // Controller state, updated when a request is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_level_reg <= LVL_ACTIVE;
            idle_ms_reg     <= '0;
        end
        else if (accept)
        begin
            power_level_reg <= power_level_next;
            idle_ms_reg     <= idle_ms_next;
        end
    end

    // Result register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    // The skid entry only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output is empty");

    // A shown result flags deep sleep exactly when its level is deep sleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.sleep_request == (rsp.level_now == LVL_DEEP_SLEEP)))
        else $error("sleep request disagrees with the reported level");

    // An accepted kick leaves the block active with a cleared count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == CMD_KICK) |=>
            (power_level_reg == LVL_ACTIVE && idle_ms_reg == '0))
        else $error("kick did not restore the active level");

    // Outside an accepted request, the level holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(power_level_reg))
        else $error("level changed without an accepted request");
`endif

endmodule

// File: test/ipsc_checker.sv
`timescale 1ns / 1ps
// Checker for the inactivity power state controller: predicts each request's result.
// Watches the request, result and register write channels; depends on ipsc_pkg.
module ipsc_checker
    import ipsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  req_t                   req,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  rsp_t                   rsp,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     result_count
);

    // Shadow copy of the registers.
    logic [31:0] dim_thr;
    logic [31:0] screen_off_thr;
    logic [31:0] light_sleep_thr;
    logic [7:0]  bl_act;
    logic [7:0]  bl_dimmed;

    // Shadow copy of the power state.
    logic [2:0]  level;
    logic [31:0] idle_count;

    rsp_t        expected_q[$];
    int          mismatches;

    assign fail_count = mismatches;

    // Backlight value that belongs to a power level.
    function automatic logic [7:0] level_backlight(input logic [2:0] lvl);
        if (lvl == LVL_ACTIVE)
            return bl_act;
        if (lvl == LVL_DIM)
            return bl_dimmed;
        return 8'd0;
    endfunction

    // Applies one request to the shadow state and returns the result it should give.
    function automatic rsp_t step_power_state(input req_t r);
        logic [2:0] want;
        logic       moved;
        rsp_t       res;
        moved = 1'b0;
        case (r.cmd)
            CMD_TICK:
            begin
                if (idle_count != 32'hFFFF_FFFF)
                    idle_count = idle_count + 32'd1;
            end
            CMD_CHECK:
            begin
                // The priority order decides when the thresholds are not ordered.
                if (idle_count >= light_sleep_thr)
                    want = LVL_LIGHT_SLEEP;
                else if (idle_count >= screen_off_thr)
                    want = LVL_SCREEN_OFF;
                else if (idle_count >= dim_thr)
                    want = LVL_DIM;
                else
                    want = LVL_ACTIVE;
                // A check only ever demotes, so deep sleep is never left here.
                if (want > level)
                begin
                    moved = 1'b1;
                    level = want;
                end
            end
            CMD_KICK:
            begin
                idle_count = 32'd0;
                moved = (level != LVL_ACTIVE);
                level = LVL_ACTIVE;
            end
            default:
            begin
                // Undefined target levels are ignored.
                if (r.target_level <= LVL_DEEP_SLEEP)
                begin
                    moved = (level != r.target_level);
                    level = r.target_level;
                end
            end
        endcase
        res.level_now       = level;
        res.backlight       = level_backlight(level);
        res.backlight_write = moved;
        res.sleep_request   = (level == LVL_DEEP_SLEEP);
        res.ms_since_kick   = idle_count;
        return res;
    endfunction

    // Compares one field and reports the first few differences.
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, name, exp_v, got_v);
        end
    endtask

    // Watch all three channels. Results are taken before requests: a result never
    // leaves in the same cycle as its own request is accepted.
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t exp_r;
        if (!rst_n)
        begin
            dim_thr         = DIM_AFTER_RESET;
            screen_off_thr  = SCREEN_OFF_AFTER_RESET;
            light_sleep_thr = LIGHT_SLEEP_AFTER_RESET;
            bl_act          = BL_ACTIVE_RESET;
            bl_dimmed       = BL_DIM_RESET;
            level           = LVL_ACTIVE;
            idle_count      = 32'd0;
            expected_q.delete();
            mismatches      = 0;
            pending      <= 0;
            result_count <= 0;
        end
        else
        begin
            // Register writes; an index past the last register is ignored.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIM_AFTER:         dim_thr         = cfg_data;
                    CFG_SCREEN_OFF_AFTER:  screen_off_thr  = cfg_data;
                    CFG_LIGHT_SLEEP_AFTER: light_sleep_thr = cfg_data;
                    CFG_BL_ACTIVE:         bl_act          = cfg_data[7:0];
                    CFG_BL_DIM:            bl_dimmed       = cfg_data[7:0];
                    default:               ;
                endcase
            end

            // Results against the oldest expectation.
            if (rsp_valid && !rsp_stall)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected, got level %0d count %0d",
                                 $realtime, rsp.level_now, rsp.ms_since_kick);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("level_now", 32'(exp_r.level_now), 32'(rsp.level_now));
                    check_field("backlight", 32'(exp_r.backlight), 32'(rsp.backlight));
                    check_field("backlight_write", 32'(exp_r.backlight_write),
                                32'(rsp.backlight_write));
                    check_field("sleep_request", 32'(exp_r.sleep_request),
                                32'(rsp.sleep_request));
                    check_field("ms_since_kick", exp_r.ms_since_kick, rsp.ms_since_kick);
                end
            end

            // Each accepted request yields exactly one result.
            if (req_valid && !req_stall)
                expected_q.push_back(step_power_state(req));

            pending <= expected_q.size();
        end
    end

endmodule

// File: test/inactivity_power_state_controller_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the inactivity power state controller: stimulus and verdict.
// Depends on ipsc_pkg, the block itself and ipsc_checker, which does all the checking.
module inactivity_power_state_controller_tb;
    import ipsc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 48;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    req_t                   req       = '0;
    logic                   rsp_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   req_stall;
    logic                   rsp_valid;
    logic                   cfg_ready;
    rsp_t                   rsp;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count = 0;
    int sent        = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    always #5 clk = ~clk;

    inactivity_power_state_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipsc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Wait in cycles before the next request or result; none in a calm phase.
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Threshold for a random setting: mostly small enough to be reached by ticks.
    function automatic logic [31:0] draw_threshold();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(1, 40);
    endfunction

    // Result side: after each accepted result, hold stall for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin : result_pacing
        int n;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            n = draw_wait();
            stall_left <= n;
            rsp_stall  <= (n != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one request after a drawn gap and waits until it is accepted.
    task automatic send_cmd(input cmd_t c, input logic [2:0] tgt);
        int   gap;
        req_t r;
        r.cmd          = c;
        r.target_level = tgt;
        gap = draw_wait();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [31:0] dim_t, input logic [31:0] off_t,
                                input logic [31:0] sleep_t, input logic [7:0] bl_a,
                                input logic [7:0] bl_d);
        write_reg(CFG_DIM_AFTER, dim_t);
        write_reg(CFG_SCREEN_OFF_AFTER, off_t);
        write_reg(CFG_LIGHT_SLEEP_AFTER, sleep_t);
        write_reg(CFG_BL_ACTIVE, {24'd0, bl_a});
        write_reg(CFG_BL_DIM, {24'd0, bl_d});
        cfg_valid <= 1'b0;
    endtask

    // Stops requesting and waits until every expected result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int   k;
        int   sel;
        cmd_t c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset settings: every command, every target
        // level including the undefined ones, deep sleep held and left.
        send_cmd(CMD_TICK, LVL_ACTIVE);
        send_cmd(CMD_CHECK, LVL_ACTIVE);
        send_cmd(CMD_KICK, LVL_ACTIVE);
        send_cmd(CMD_FORCE, LVL_DIM);
        send_cmd(CMD_FORCE, LVL_DIM);
        send_cmd(CMD_FORCE, LVL_SCREEN_OFF);
        send_cmd(CMD_CHECK, LVL_ACTIVE);
        send_cmd(CMD_FORCE, LVL_LIGHT_SLEEP);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP);
        send_cmd(CMD_TICK, LVL_ACTIVE);
        send_cmd(CMD_CHECK, LVL_ACTIVE);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP + 3'd1);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP + 3'd2);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP + 3'd3);
        send_cmd(CMD_KICK, LVL_DEEP_SLEEP + 3'd3);
        send_cmd(CMD_FORCE, LVL_ACTIVE);
        send_cmd(CMD_TICK, LVL_DEEP_SLEEP);
        send_cmd(CMD_TICK, LVL_LIGHT_SLEEP);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP);
        send_cmd(CMD_FORCE, LVL_DEEP_SLEEP);
        send_cmd(CMD_KICK, LVL_ACTIVE);
        drain();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            calm = (phase % 4 == 2);
            case (phase)
                // Zero dim threshold, unreachable upper thresholds, lowest backlights.
                0: program_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 8'd0);
                1:
                begin
                    write_reg(CFG_BL_DIM + 3'd1 + 3'($urandom_range(0, 2)), $urandom);
                    program_regs(32'd3, 32'd8, 32'd15, 8'd255, 8'd255);
                end
                // Thresholds out of order.
                2: program_regs(32'd20, 32'd6, 32'd12, 8'hAA, 8'h55);
                // Light sleep threshold of zero overrides the others.
                3: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd128);
                default: program_regs(draw_threshold(), draw_threshold(), draw_threshold(),
                                      8'($urandom), 8'($urandom));
            endcase

            // Mostly ticks with checks mixed in, so the thresholds are reached;
            // kicks and forces are rarer so the idle count can grow.
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    c = CMD_TICK;
                else if (sel < 80)
                    c = CMD_CHECK;
                else if (sel < 86)
                    c = CMD_KICK;
                else
                    c = CMD_FORCE;
                send_cmd(c, 3'($urandom_range(0, 7)));
            end
            drain();
        end

        $display("Summary: %0d requests, directed ones under the reset setting, then %0d",
                 sent, PHASES);
        $display("         random phases with their own register settings; %0d results checked,",
                 result_count);
        $display("         %0d mismatches.", fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/ipsc_pkg.sv
hdl/inactivity_power_state_controller.sv
test/ipsc_checker.sv
test/inactivity_power_state_controller_tb.sv
